// ----- hw/rtl/cep_pkg.sv -----
// shared types, field widths and constants for the calendar to epoch converter
// no dependencies; used by cep_days, calendar_to_epoch_offset and cep_check
package cep_pkg;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int LMS_W    = 32;
    localparam int EPOCH_W  = 34;
    localparam int OFS_W    = 45;

    // packed stream widths
    localparam int S_DATA_W = 72;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 80;

    // tuser bit positions
    localparam int USER_DATE_OK = 0;
    localparam int USER_TIME_OK = 1;

    // internal widths
    localparam int QUO_W   = 6;   // year / 100 for a 12 bit year
    localparam int REM_W   = 7;   // year % 100
    localparam int LEAP_W  = 11;  // y/4 - y/100 + y/400
    localparam int MST_W   = 9;   // cumulative days before a month
    localparam int DAYS_W  = 22;  // signed day count since epoch
    localparam int TOD_W   = 17;  // seconds into the day
    localparam int SECS_W  = 45;  // seconds, kept modulo 2^45

    localparam int EPOCH_YEAR    = 1970;
    localparam int YEAR_DAYS     = 365;
    localparam int LEAPS_EPOCH   = 477;   // leap count through 1970
    localparam int RECIP_100     = 5243;  // ceil(2^19 / 100)
    localparam int RECIP_SHIFT   = 19;
    localparam int DAY_SECONDS   = 86400;
    localparam int HOUR_SECONDS  = 3600;
    localparam int MINUTE_SECONDS = 60;
    localparam int MS_PER_SECOND = 1000;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [LMS_W-1:0]    local_ms;
    } rec_t;

    typedef struct packed {
        logic signed [DAYS_W-1:0] days;
        logic [TOD_W-1:0]         tod;
        logic [LMS_W-1:0]         local_ms;
    } day_rec_t;

    // days in the year before the first of the given month
    function automatic logic [MST_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [MST_W-1:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ----- hw/rtl/cep_days.sv -----
// three stage pipeline turning a calendar record into a signed day count
// and seconds into the day; depends on cep_pkg
module cep_days
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cep_pkg::rec_t     in_rec,
    output logic              out_valid,
    input  logic              out_ready,
    output cep_pkg::day_rec_t out_rec
);

    // stage a: record, year / 100, month table
    logic                            a_valid_reg;
    cep_pkg::rec_t                   a_rec_reg;
    logic [cep_pkg::QUO_W-1:0]       a_quo_reg;
    logic [cep_pkg::MST_W-1:0]       a_mst_reg;
    logic                            a_jf_reg;
    logic                            a_ready;
    logic [cep_pkg::QUO_W-1:0]       a_quo_next;
    logic [24:0]                     a_prod;

    // stage b: year base, leap count, leap flag, time of day
    logic                            b_valid_reg;
    logic signed [cep_pkg::DAYS_W-1:0] b_base_reg;
    logic [cep_pkg::LEAP_W-1:0]      b_leaps_reg;
    logic                            b_corr_reg;
    logic [cep_pkg::MST_W-1:0]       b_mst_reg;
    logic [cep_pkg::DAY_W-1:0]       b_day_reg;
    logic [cep_pkg::TOD_W-1:0]       b_tod_reg;
    logic [cep_pkg::LMS_W-1:0]       b_lms_reg;
    logic                            b_ready;
    logic [cep_pkg::YEAR_W-1:0]      b_rem_full;
    logic [cep_pkg::REM_W-1:0]       b_rem;
    logic                            b_leap;
    logic signed [12:0]              b_year_off;
    logic signed [cep_pkg::DAYS_W-1:0] b_base_next;
    logic [cep_pkg::LEAP_W-1:0]      b_leaps_next;
    logic [cep_pkg::TOD_W-1:0]       b_tod_next;

    // stage c: day count
    logic                            c_valid_reg;
    cep_pkg::day_rec_t               c_rec_reg;
    logic                            c_ready;
    logic signed [cep_pkg::DAYS_W-1:0] c_days_next;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // reciprocal multiply, exact for any 12 bit year
    assign a_prod     = 25'(in_rec.year) * 25'(cep_pkg::RECIP_100);
    assign a_quo_next = a_prod[cep_pkg::RECIP_SHIFT +: cep_pkg::QUO_W];

    assign b_rem_full = a_rec_reg.year - 12'(a_quo_reg) * 12'd100;
    assign b_rem      = b_rem_full[cep_pkg::REM_W-1:0];
    assign b_leap     = (a_rec_reg.year[1:0] == 2'b00 && b_rem != '0)
                        || (b_rem == '0 && a_quo_reg[1:0] == 2'b00);
    assign b_year_off = $signed({1'b0, a_rec_reg.year}) - 13'(cep_pkg::EPOCH_YEAR);
    assign b_base_next = 22'(b_year_off) * 22'(cep_pkg::YEAR_DAYS);
    assign b_leaps_next = 11'(a_rec_reg.year[cep_pkg::YEAR_W-1:2]) - 11'(a_quo_reg)
                          + 11'(a_quo_reg[cep_pkg::QUO_W-1:2]);
    assign b_tod_next = 17'(a_rec_reg.hour) * 17'(cep_pkg::HOUR_SECONDS)
                        + 17'(a_rec_reg.minute) * 17'(cep_pkg::MINUTE_SECONDS)
                        + 17'(a_rec_reg.second);

    // leap day of this year not yet reached in january and february
    assign c_days_next = b_base_reg + $signed(22'(b_leaps_reg))
                         - 22'(cep_pkg::LEAPS_EPOCH)
                         + $signed(22'(b_mst_reg)) + $signed(22'(b_day_reg))
                         - 22'sd1 - $signed(22'(b_corr_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_rec_reg <= in_rec;
            a_quo_reg <= a_quo_next;
            a_mst_reg <= cep_pkg::month_start(in_rec.month);
            a_jf_reg  <= (in_rec.month == cep_pkg::MONTH_JAN)
                         || (in_rec.month == cep_pkg::MONTH_FEB);
        end
        if (b_ready && a_valid_reg)
        begin
            b_base_reg  <= b_base_next;
            b_leaps_reg <= b_leaps_next;
            b_corr_reg  <= a_jf_reg && b_leap;
            b_mst_reg   <= a_mst_reg;
            b_day_reg   <= a_rec_reg.day;
            b_tod_reg   <= b_tod_next;
            b_lms_reg   <= a_rec_reg.local_ms;
        end
        if (c_ready && b_valid_reg)
        begin
            c_rec_reg.days     <= c_days_next;
            c_rec_reg.tod      <= b_tod_reg;
            c_rec_reg.local_ms <= b_lms_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_rec   = c_rec_reg;

endmodule

// ----- hw/rtl/calendar_to_epoch_offset.sv -----
// calendar_to_epoch_offset: top level of the utc calendar to unix time converter
// depends on cep_pkg and cep_days
//
// usage
//   slave stream carries one calendar record per beat; tuser holds the date
//   and time validity flags. a beat with either flag clear is taken and
//   dropped, producing nothing. a beat with both flags set produces one
//   master beat with epoch seconds and the millisecond offset
//   (epoch seconds * 1000 - local millisecond counter, two's complement).
//   each accepted beat passes five register stages (divide by 100, year base,
//   day count, seconds, offset), the first loaded at the accepting edge itself.
//   throughput: one beat per cycle while m_axis_tready stays high; each stage
//   holds one record and moves on whenever the stage after it is empty or
//   moving, so bubbles close up. when the receiver stalls, the output beat
//   holds steady and the stages behind it keep filling; s_axis_tready drops
//   only once all five are full.
//   reset clears every stage valid bit; no result is pending after reset.
module calendar_to_epoch_offset
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
    // second[37:32], local_ms[69:38], zero pad[71:70]
    input  logic [71:0] s_axis_tdata,
    // date_ok[0], time_ok[1]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // epoch_seconds[33:0], offset_ms[78:34], zero pad[79]
    output logic [79:0] m_axis_tdata
);

    cep_pkg::rec_t     in_rec;
    logic              in_valid;
    logic              days_valid;
    logic              days_ready;
    cep_pkg::day_rec_t days_rec;

    logic                             d_valid_reg;
    logic [cep_pkg::SECS_W-1:0]       d_secs_reg;
    logic [cep_pkg::LMS_W-1:0]        d_lms_reg;
    logic                             d_ready;
    logic signed [cep_pkg::SECS_W-1:0] d_secs_next;

    logic                             e_valid_reg;
    logic [cep_pkg::EPOCH_W-1:0]      e_epoch_reg;
    logic [cep_pkg::OFS_W-1:0]        e_ofs_reg;
    logic                             e_ready;
    logic [cep_pkg::OFS_W-1:0]        e_ofs_next;

    assign in_rec.year     = s_axis_tdata[11:0];
    assign in_rec.month    = s_axis_tdata[15:12];
    assign in_rec.day      = s_axis_tdata[20:16];
    assign in_rec.hour     = s_axis_tdata[25:21];
    assign in_rec.minute   = s_axis_tdata[31:26];
    assign in_rec.second   = s_axis_tdata[37:32];
    assign in_rec.local_ms = s_axis_tdata[69:38];

    assign in_valid = s_axis_tvalid && s_axis_tuser[cep_pkg::USER_DATE_OK]
                      && s_axis_tuser[cep_pkg::USER_TIME_OK];

    cep_days u_days
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (s_axis_tready),
        .in_rec    (in_rec),
        .out_valid (days_valid),
        .out_ready (days_ready),
        .out_rec   (days_rec)
    );

    assign e_ready    = !e_valid_reg || m_axis_tready;
    assign d_ready    = !d_valid_reg || e_ready;
    assign days_ready = d_ready;

    // seconds kept modulo 2^45, enough for both output fields
    assign d_secs_next = 45'(days_rec.days) * 45'(cep_pkg::DAY_SECONDS)
                         + $signed(45'(days_rec.tod));
    assign e_ofs_next  = d_secs_reg * 45'(cep_pkg::MS_PER_SECOND) - 45'(d_lms_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            if (d_ready)
            begin
                d_valid_reg <= days_valid;
            end
            if (e_ready)
            begin
                e_valid_reg <= d_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ready && days_valid)
        begin
            d_secs_reg <= d_secs_next;
            d_lms_reg  <= days_rec.local_ms;
        end
        if (e_ready && d_valid_reg)
        begin
            e_epoch_reg <= d_secs_reg[cep_pkg::EPOCH_W-1:0];
            e_ofs_reg   <= e_ofs_next;
        end
    end

    assign m_axis_tvalid = e_valid_reg;
    assign m_axis_tdata  = {1'b0, e_ofs_reg, e_epoch_reg};

endmodule

// ----- hw/rtl/cep_check.sv -----
// port level checker for calendar_to_epoch_offset, bound to the top level
// depends on cep_pkg
module cep_check
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);

    localparam int DEPTH = 5;

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       take;
    logic       give;

    // beats with both flags set are the only ones owed a result
    assign take = s_axis_tvalid && s_axis_tready
                  && s_axis_tuser[cep_pkg::USER_DATE_OK]
                  && s_axis_tuser[cep_pkg::USER_TIME_OK];
    assign give = m_axis_tvalid && m_axis_tready;
    assign pending_next = pending_reg + 3'(take) - 3'(give);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 3'd0)
        else $error("result with no flagged record outstanding");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'(DEPTH))
        else $error("more records in flight than pipeline stages");

    a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg < 3'(DEPTH) && !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with room in the pipeline");

endmodule

bind calendar_to_epoch_offset cep_check u_cep_check (.*);

// ----- sim/tb_top.sv -----
// tb_top: self-checking bench for calendar_to_epoch_offset, a directed table then random records
// predicts epoch seconds and millisecond offset per accepted beat; depends on cep_pkg and the rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam real CLK_PERIOD   = 4.0;
    localparam int  RANDOM_ITEMS = 880;
    localparam int  PHASE_ITEMS  = 293;
    localparam int  DRAIN_CYCLES = 20;
    localparam int  CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [cep_pkg::EPOCH_W-1:0] epoch_seconds;
        logic [cep_pkg::OFS_W-1:0]   offset_ms;
    } epoch_result_t;

    typedef enum logic {CHECK_MODEL, CHECK_TYPED} row_check_t;

    typedef struct packed {
        cep_pkg::rec_t rec;
        logic          date_ok;
        logic          time_ok;
        row_check_t    check;
        epoch_result_t want;
    } dir_row_t;

    localparam epoch_result_t NO_RESULT = '0;

    // cumulative days before the first of each month, months 0 and 13..15 add nothing
    localparam logic [8:0] DAYS_BEFORE_MONTH [16] = '{
        9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
    };

    localparam int DIR_ROWS = 23;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // epoch origin, then counter extremes and one second against it
        '{'{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1, 1'b1, CHECK_TYPED,
          '{34'd0, 45'd0}},
        '{'{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd1}, 1'b1, 1'b1, CHECK_TYPED,
          '{34'd0, 45'h1FFF_FFFF_FFFF}},
        '{'{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd1, 32'd0}, 1'b1, 1'b1, CHECK_TYPED,
          '{34'd1, 45'd1000}},
        '{'{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'hFFFF_FFFF}, 1'b1, 1'b1, CHECK_TYPED,
          '{34'd0, 45'h1FFF_0000_0001}},
        // 2^31 seconds
        '{'{12'd2038, 4'd1, 5'd19, 5'd3, 6'd14, 6'd8, 32'd0}, 1'b1, 1'b1, CHECK_TYPED,
          '{34'd2147483648, 45'h1F4_0000_0000}},
        // one second before the epoch wraps both fields
        '{'{12'd1969, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 32'd0}, 1'b1, 1'b1, CHECK_TYPED,
          '{34'h3_FFFF_FFFF, 45'h1FFF_FFFF_FC18}},
        // flag clear: no beat out; then a flagged late year with second 60 and a full counter
        '{'{12'd2000, 4'd6, 5'd15, 5'd12, 6'd0, 6'd0, 32'd5}, 1'b0, 1'b1, CHECK_MODEL,
          NO_RESULT},
        '{'{12'd2000, 4'd6, 5'd15, 5'd12, 6'd0, 6'd0, 32'd5}, 1'b1, 1'b0, CHECK_MODEL,
          NO_RESULT},
        '{'{12'd2000, 4'd6, 5'd15, 5'd12, 6'd0, 6'd0, 32'd5}, 1'b0, 1'b0, CHECK_MODEL,
          NO_RESULT},
        '{'{12'd2399, 4'd12, 5'd31, 5'd23, 6'd59, 6'd60, 32'hFFFF_FFFF}, 1'b1, 1'b1,
          CHECK_MODEL, NO_RESULT},
        // leap day handling around jan, feb and march
        '{'{12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1, 1'b1, CHECK_MODEL,
          NO_RESULT},
        '{'{12'd2000, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59, 32'd123}, 1'b1, 1'b1, CHECK_MODEL,
          NO_RESULT},
        '{'{12'd2000, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1, 1'b1, CHECK_MODEL,
          NO_RESULT},
        '{'{12'd1900, 4'd2, 5'd28, 5'd6, 6'd30, 6'd0, 32'd77}, 1'b1, 1'b1, CHECK_MODEL,
          NO_RESULT},
        '{'{12'd2100, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 32'd9}, 1'b1, 1'b1, CHECK_MODEL,
          NO_RESULT},
        '{'{12'd2024, 4'd2, 5'd29, 5'd12, 6'd30, 6'd45, 32'h8000_0000}, 1'b1, 1'b1,
          CHECK_MODEL, NO_RESULT},
        // months outside 1..12
        '{'{12'd2023, 4'd0, 5'd10, 5'd1, 6'd2, 6'd3, 32'd4}, 1'b1, 1'b1, CHECK_MODEL,
          NO_RESULT},
        '{'{12'd2023, 4'd13, 5'd10, 5'd1, 6'd2, 6'd3, 32'd4}, 1'b1, 1'b1, CHECK_MODEL,
          NO_RESULT},
        '{'{12'd2024, 4'd15, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1, 1'b1, CHECK_MODEL,
          NO_RESULT},
        // out of range day and time fields are taken as given, then the year extremes
        '{'{12'd2021, 4'd7, 5'd0, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1, 1'b1, CHECK_MODEL,
          NO_RESULT},
        '{'{12'd1985, 4'd5, 5'd31, 5'd31, 6'd63, 6'd63, 32'd1000}, 1'b1, 1'b1, CHECK_MODEL,
          NO_RESULT},
        '{'{12'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1, 1'b1, CHECK_MODEL,
          NO_RESULT},
        '{'{12'd4095, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 32'd0}, 1'b1, 1'b1, CHECK_MODEL,
          NO_RESULT}
    };

    logic                         clk;
    logic                         rst_n;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [cep_pkg::S_DATA_W-1:0] s_axis_tdata;
    logic [cep_pkg::S_USER_W-1:0] s_axis_tuser;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [cep_pkg::M_DATA_W-1:0] m_axis_tdata;

    // record on the bus and how its result is to be checked
    cep_pkg::rec_t driven_rec;
    row_check_t    driven_check;
    epoch_result_t driven_want;

    epoch_result_t pending_results [$];
    int            fail_count = 0;
    int            cycle_count = 0;
    int            send_idle_pct;
    int            recv_idle_pct;

    calendar_to_epoch_offset dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [63:0] leap_count(input logic [63:0] y);
        return y / 4 - y / 100 + y / 400;
    endfunction

    // arithmetic mod 2^64, so years before 1970 and day 0 wrap like two's complement
    function automatic epoch_result_t calc_epoch_offset(input cep_pkg::rec_t r);
        logic [63:0]   yr;
        logic [63:0]   secs;
        logic [63:0]   ms;
        logic          leap;
        epoch_result_t res;
        yr   = 64'(r.year);
        leap = ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
        secs = (yr - 64'(cep_pkg::EPOCH_YEAR)) * 64'(cep_pkg::YEAR_DAYS) + leap_count(yr)
               - leap_count(64'(cep_pkg::EPOCH_YEAR)) + 64'(DAYS_BEFORE_MONTH[r.month]);
        if ((r.month == cep_pkg::MONTH_JAN || r.month == cep_pkg::MONTH_FEB) && leap)
            secs = secs - 64'd1;
        secs = secs + 64'(r.day) - 64'd1;
        secs = secs * 64'd24 + 64'(r.hour);
        secs = secs * 64'd60 + 64'(r.minute);
        secs = secs * 64'd60 + 64'(r.second);
        ms   = secs * 64'(cep_pkg::MS_PER_SECOND) - 64'(r.local_ms);
        res.epoch_seconds = secs[cep_pkg::EPOCH_W-1:0];
        res.offset_ms     = ms[cep_pkg::OFS_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // mostly plausible records, some full-width fields and some flag-clear noise
    task automatic random_record(output cep_pkg::rec_t r, output logic dok,
                                 output logic tok);
        logic [1:0] flags;
        r.year   = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(2399, 1970));
        r.month  = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(12, 1));
        r.day    = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(31, 1));
        r.hour   = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(23, 0));
        r.minute = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(59, 0));
        r.second = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(60, 0));
        r.local_ms = $urandom;
        // near the epoch the counter can exceed epoch ms, giving a negative offset
        if ($urandom_range(9) == 0)
        begin
            r.year  = 12'(cep_pkg::EPOCH_YEAR);
            r.month = cep_pkg::MONTH_JAN;
        end
        if ($urandom_range(99) < 85)
        begin
            dok = 1'b1;
            tok = 1'b1;
        end
        else
        begin
            flags = 2'($urandom_range(2, 0));
            dok   = flags[0];
            tok   = flags[1];
        end
    endtask

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(input cep_pkg::rec_t r, input logic dok, input logic tok,
                             input row_check_t check, input epoch_result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, r.local_ms, r.second, r.minute, r.hour, r.day, r.month,
                          r.year};
        s_axis_tuser  <= {tok, dok};
        driven_rec    <= r;
        driven_check  <= check;
        driven_want   <= want;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // scoreboard: expectations pushed on input beats, checked on output beats
    always @(posedge clk)
    begin
        epoch_result_t got;
        epoch_result_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready && s_axis_tuser[cep_pkg::USER_DATE_OK]
                && s_axis_tuser[cep_pkg::USER_TIME_OK])
            begin
                if (driven_check == CHECK_TYPED)
                    pending_results.push_back(driven_want);
                else
                    pending_results.push_back(calc_epoch_offset(driven_rec));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.epoch_seconds = m_axis_tdata[cep_pkg::EPOCH_W-1:0];
                got.offset_ms     = m_axis_tdata[cep_pkg::EPOCH_W +: cep_pkg::OFS_W];
                if (pending_results.size() == 0)
                    report_mismatch("beat with nothing expected", 64'(got.epoch_seconds), 64'd0);
                else
                begin
                    want = pending_results.pop_front();
                    if (got.epoch_seconds !== want.epoch_seconds)
                        report_mismatch("epoch_seconds", 64'(got.epoch_seconds),
                                        64'(want.epoch_seconds));
                    if (got.offset_ms !== want.offset_ms)
                        report_mismatch("offset_ms", 64'(got.offset_ms), 64'(want.offset_ms));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        cep_pkg::rec_t r;
        logic dok;
        logic tok;
        int   items_sent;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        driven_rec    = '0;
        driven_check  = CHECK_MODEL;
        driven_want   = NO_RESULT;
        send_idle_pct = 6;
        recv_idle_pct = 56;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[i])
            send_beat(DIRECTED[i].rec, DIRECTED[i].date_ok, DIRECTED[i].time_ok,
                      DIRECTED[i].check, DIRECTED[i].want);

        // every random beat counts, flag-clear ones included
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent == PHASE_ITEMS)
            begin
                send_idle_pct = 56;
                recv_idle_pct = 6;
            end
            else if (items_sent == 2 * PHASE_ITEMS)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_record(r, dok, tok);
            send_beat(r, dok, tok, CHECK_MODEL, NO_RESULT);
            items_sent++;
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
